FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, disabled while rst_n is low
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check on clk, disabled while rst_n is low
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check on clk, disabled while rst_n is low
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ftprc_pkg.sv
`timescale 1ns / 1ps

package ftprc_pkg;

    localparam int unsigned CODE_W    = 10;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned IN_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [LEN_W-1:0] CODE_LEN = 3'd3;
    localparam logic [LEN_W-1:0] LEN_MAX  = 3'd4;
    localparam logic [MS_W-1:0]  MS_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [7:0]      rx_byte;
        logic [MS_W-1:0] timeout_ms;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] reply_code;
        logic              timed_out;
    } result_t;

endpackage

FILE: rtl/ftprc_in_stage.sv
`timescale 1ns / 1ps

module ftprc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ftprc_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output ftprc_pkg::item_t item
);
    import ftprc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/ftprc_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftprc_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  ftprc_pkg::item_t   item,
    input  logic               fire,
    output ftprc_pkg::result_t res
);
    import ftprc_pkg::*;

    logic              waiting_reg,        waiting_next;
    logic [MS_W-1:0]   elapsed_reg,        elapsed_next;
    logic [MS_W-1:0]   limit_reg,          limit_next;
    logic [LEN_W-1:0]  line_len_reg,       line_len_next;
    logic [CODE_W-1:0] line_value_reg,     line_value_next;
    logic              digits_ok_reg,      digits_ok_next;
    logic [7:0]        sep_reg,            sep_next;
    logic [CODE_W-1:0] first_code_reg,     first_code_next;
    logic              have_first_reg,     have_first_next;
    logic              multi_reg,          multi_next;

    logic              is_digit;
    logic [CODE_W-1:0] digit_val;
    logic [CODE_W-1:0] value_x10;
    logic [MS_W-1:0]   elapsed_inc;
    logic              line_is_code;

    assign is_digit     = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
    assign digit_val    = {{(CODE_W-4){1'b0}}, item.rx_byte[3:0]};
    assign value_x10    = {line_value_reg[CODE_W-4:0], 3'b000}
                        + {line_value_reg[CODE_W-2:0], 1'b0};
    assign elapsed_inc  = (elapsed_reg != MS_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign line_is_code = (line_len_reg >= CODE_LEN) && digits_ok_reg;

    always_comb
    begin
        waiting_next    = waiting_reg;
        elapsed_next    = elapsed_reg;
        limit_next      = limit_reg;
        line_len_next   = line_len_reg;
        line_value_next = line_value_reg;
        digits_ok_next  = digits_ok_reg;
        sep_next        = sep_reg;
        first_code_next = first_code_reg;
        have_first_next = have_first_reg;
        multi_next      = multi_reg;
        res             = '0;

        unique case (item.req_type)
            REQ_START:
            begin
                waiting_next    = 1'b1;
                elapsed_next    = '0;
                limit_next      = item.timeout_ms;
                line_len_next   = '0;
                line_value_next = '0;
                digits_ok_next  = 1'b1;
                sep_next        = CH_SPACE;
                first_code_next = '0;
                have_first_next = 1'b0;
                multi_next      = 1'b0;
                if (item.timeout_ms == '0)
                begin
                    res.valid     = 1'b1;
                    res.timed_out = 1'b1;
                    waiting_next  = 1'b0;
                end
            end
            REQ_BYTE:
            begin
                if (waiting_reg && item.rx_byte != CH_CR)
                begin
                    if (item.rx_byte == CH_LF)
                    begin
                        // end of line: check for a reply code
                        if (line_is_code)
                        begin
                            if (!have_first_reg)
                            begin
                                first_code_next = line_value_reg;
                                have_first_next = 1'b1;
                                multi_next      = (sep_reg == CH_DASH);
                                if (sep_reg != CH_DASH)
                                begin
                                    res.valid      = 1'b1;
                                    res.reply_code = line_value_reg;
                                    waiting_next   = 1'b0;
                                end
                            end
                            else if (multi_reg && line_value_reg == first_code_reg
                                     && sep_reg == CH_SPACE)
                            begin
                                res.valid      = 1'b1;
                                res.reply_code = line_value_reg;
                                waiting_next   = 1'b0;
                            end
                        end
                        line_len_next   = '0;
                        line_value_next = '0;
                        digits_ok_next  = 1'b1;
                        sep_next        = CH_SPACE;
                    end
                    else
                    begin
                        if (line_len_reg < CODE_LEN)
                        begin
                            if (is_digit)
                            begin
                                line_value_next = value_x10 + digit_val;
                            end
                            else
                            begin
                                digits_ok_next = 1'b0;
                            end
                        end
                        else if (line_len_reg == CODE_LEN)
                        begin
                            sep_next = item.rx_byte;
                        end
                        if (line_len_reg < LEN_MAX)
                        begin
                            line_len_next = line_len_reg + 1'b1;
                        end
                    end
                end
            end
            REQ_TICK:
            begin
                if (waiting_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= limit_reg)
                    begin
                        res.valid     = 1'b1;
                        res.timed_out = 1'b1;
                        waiting_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg    <= 1'b0;
            elapsed_reg    <= '0;
            limit_reg      <= '0;
            line_len_reg   <= '0;
            line_value_reg <= '0;
            digits_ok_reg  <= 1'b1;
            sep_reg        <= CH_SPACE;
            first_code_reg <= '0;
            have_first_reg <= 1'b0;
            multi_reg      <= 1'b0;
        end
        else if (fire)
        begin
            waiting_reg    <= waiting_next;
            elapsed_reg    <= elapsed_next;
            limit_reg      <= limit_next;
            line_len_reg   <= line_len_next;
            line_value_reg <= line_value_next;
            digits_ok_reg  <= digits_ok_next;
            sep_reg        <= sep_next;
            first_code_reg <= first_code_next;
            have_first_reg <= have_first_next;
            multi_reg      <= multi_next;
        end
    end

    `CHK_IMPLY(a_res_needs_wait, res.valid && item.req_type != REQ_START, waiting_reg,
               "result from a beat while not waiting")
    `CHK_NEXT(a_done_after_res, fire && res.valid, !waiting_reg,
              "still waiting after a result")
    `CHK_IMPLY(a_timeout_code, res.valid && res.timed_out, res.reply_code == '0,
               "timeout result with nonzero code")
    `CHK_ASSERT(a_len_range, line_len_reg <= LEN_MAX, "line length past limit")

endmodule

FILE: rtl/ftprc_out_stage.sv
`timescale 1ns / 1ps

module ftprc_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  ftprc_pkg::result_t res,
    input  logic               load,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output ftprc_pkg::result_t out_res
);
    import ftprc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign busy       = valid_reg && !out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: rtl/ftp_reply_code_parser_core.sv
// path: input stage register, combinational parser, then output stage register
// throughput: one input beat per cycle unless a result is stalled, set by the single-pass update of the line state
// a stalled result holds the input stage, and every beat behind it, only while the held
// beat would produce another result
// reset: rst_n asynchronous active low, clears the valid flags and parser state; the block then ignores
// byte and tick beats until a start beat arrives
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftp_reply_code_parser_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ftprc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // rx_byte, timeout_ms
    input  logic [1:0]                 s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ftprc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // reply_code, zero fill
    output logic                       m_axis_tuser   // timed_out
);
    import ftprc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    logic    out_busy;
    result_t res;
    result_t out_res;

    assign in_item.req_type   = s_axis_tuser;
    assign in_item.rx_byte    = s_axis_tdata[7:0];
    assign in_item.timeout_ms = s_axis_tdata[8 +: MS_W];

    assign fire = item_valid && !(res.valid && out_busy);

    ftprc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    ftprc_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .fire  (fire),
        .res   (res)
    );

    ftprc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .load      (fire && res.valid),
        .busy      (out_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-CODE_W){1'b0}}, out_res.reply_code};
    assign m_axis_tuser = out_res.timed_out;

    `CHK_IMPLY(a_no_overwrite, m_axis_tvalid && !m_axis_tready, !(fire && res.valid),
               "pending result overwritten")
    `CHK_NEXT(a_load_shows, fire && res.valid, m_axis_tvalid,
              "loaded result not presented")

endmodule
